// ===== sv/uth_pkg.sv =====
`timescale 1ns / 1ps

package uth_pkg;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned TICK_W = 16;
  localparam int unsigned HELD_W = 13;
  localparam int unsigned BITS_W = 4;

  localparam logic [TICK_W-1:0] BIT_TICKS_RESET = 16'd200;
  localparam logic [BITS_W-1:0] FRAME_BITS = 4'd10;

  typedef enum logic [FUNC_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_SUSPEND = 2'd1,
    OP_RESUME  = 2'd2,
    OP_TICK    = 2'd3
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [DATA_W-1:0] data;
    logic              last;
  } item_t;

  typedef struct packed {
    logic              pin;
    logic              accepted;
    logic              busy;
    logic [HELD_W-1:0] held;
  } res_t;

endpackage

// ===== sv/uart_tx_with_hold_buffer.sv =====
`timescale 1ns / 1ps

// Serial 8N1 transmitter with a byte queue and a hold buffer for suspended output.
// Items enter through push/full: write byte, suspend, resume, or one timer tick.
// An item transfers at a rising edge with push high and full low.
// Every item yields exactly one result (pin level, accepted, busy, held count),
// read through empty/pop; a result transfers at an edge with pop high and empty low.
// A result reaches the result ports through the item queue and the engine into the
// result queue; its item waits in the item queue while the result queue is full.
// One item is processed per clock while the two-entry result queue has room,
// so items may arrive on every cycle; the engine works on an item only then.
// When the receiver stops popping, both queues fill and full rises.
// The bit period is set by cfg_wdata_i, written while cfg_we_i is high.
// Reset empties both queues, sets the bit period to 200 ticks,
// enables output and drives the pin high; the byte store is not cleared.
module uart_tx_with_hold_buffer #(
  parameter int unsigned QUEUE_DEPTH = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [uth_pkg::TICK_W-1:0]     cfg_wdata_i,
  input  logic                           push,
  output logic                           full,
  input  logic [uth_pkg::FUNC_W-1:0]     func_i,
  input  logic [uth_pkg::DATA_W-1:0]     data_i,
  input  logic                           last_of_write_i,
  output logic                           empty,
  input  logic                           pop,
  output logic                           pin_o,
  output logic                           accepted_o,
  output logic                           busy_res_o,
  output logic [uth_pkg::HELD_W-1:0]     held_count_o
);

  import uth_pkg::*;

  item_t item;
  res_t  res_in, res_out;
  logic  avail, res_full, step;

  assign step = avail && !res_full;

  uth_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .func_i         (func_i),
    .data_i         (data_i),
    .last_of_write_i(last_of_write_i),
    .take_i         (step),
    .avail_o        (avail),
    .item_o         (item)
  );

  uth_engine #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .step_i     (step),
    .item_i     (item),
    .res_o      (res_in)
  );

  uth_fifo #(
    .Width($bits(res_t))
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (step),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_out),
    .empty_o(empty)
  );

  assign pin_o        = res_out.pin;
  assign accepted_o   = res_out.accepted;
  assign busy_res_o   = res_out.busy;
  assign held_count_o = res_out.held;

endmodule

// ===== sv/uth_fifo.sv =====
`timescale 1ns / 1ps

module uth_fifo #(
  parameter int unsigned Width = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  logic [1:0][Width-1:0] slot_q;
  logic                  wr_q, wr_d;
  logic                  rd_q, rd_d;
  logic [1:0]            cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== sv/uth_front.sv =====
`timescale 1ns / 1ps

module uth_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  output logic                           full_o,
  input  logic [uth_pkg::FUNC_W-1:0]     func_i,
  input  logic [uth_pkg::DATA_W-1:0]     data_i,
  input  logic                           last_of_write_i,
  input  logic                           take_i,
  output logic                           avail_o,
  output uth_pkg::item_t                 item_o
);

  import uth_pkg::*;

  item_t item_in;
  logic  q_empty;

  always_comb begin
    item_in.op   = op_e'(func_i);
    item_in.data = data_i;
    item_in.last = last_of_write_i;
  end

  uth_fifo #(
    .Width($bits(item_t))
  ) u_item_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (item_in),
    .full_o (full_o),
    .pop_i  (take_i),
    .data_o (item_o),
    .empty_o(q_empty)
  );

  assign avail_o = !q_empty;

endmodule

// ===== sv/uth_engine.sv =====
`timescale 1ns / 1ps

module uth_engine #(
  parameter int unsigned QUEUE_DEPTH = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [uth_pkg::TICK_W-1:0] cfg_wdata_i,
  input  logic                       step_i,
  input  uth_pkg::item_t             item_i,
  output uth_pkg::res_t              res_o
);

  import uth_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [TICK_W-1:0] bit_ticks_q;
  logic [PW-1:0]     wp_q, wp_d, rp_q, rp_d, wp_inc, rp_inc;
  logic [CW-1:0]     rel_q, rel_d, held_q, held_d;
  logic              susp_q, susp_d, skip_q, skip_d;
  logic [DATA_W:0]   shift_q, shift_d;
  logic [BITS_W-1:0] bits_q, bits_d;
  logic [TICK_W-1:0] tick_q, tick_d, limit;
  logic              line_q, line_d;

  logic [DATA_W-1:0] mem_q [QUEUE_DEPTH];
  logic [DATA_W-1:0] rd_q, head_q, head_d, head;
  logic              pf_q, pf_d;

  logic              mem_we, start, ok;
  logic [CW:0]       occ, wsum;
  logic [CW+HELD_W-1:0] held_ext;

  assign wp_inc = (wp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + PW'(1);
  assign rp_inc = (rp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + PW'(1);
  assign limit  = (bit_ticks_q == '0) ? TICK_W'(1) : bit_ticks_q;
  assign occ    = {1'b0, rel_q} + {1'b0, held_q};
  assign wsum   = {1'b0, rel_q} + (CW + 1)'(rp_q);
  assign head   = pf_q ? rd_q : head_q;

  always_comb begin
    wp_d   = wp_q;
    rp_d   = rp_q;
    rel_d  = rel_q;
    held_d = held_q;
    susp_d = susp_q;
    skip_d = skip_q;
    shift_d = shift_q;
    bits_d = bits_q;
    tick_d = tick_q;
    line_d = line_q;
    mem_we = 1'b0;
    start  = 1'b0;
    ok     = 1'b0;
    if (step_i) begin
      unique case (item_i.op)
        OP_WRITE: begin
          if (!skip_q) begin
            if (item_i.data == '0) begin
              skip_d = 1'b1;
            end else if (occ < (CW + 1)'(QUEUE_DEPTH)) begin
              mem_we = 1'b1;
              wp_d   = wp_inc;
              ok     = 1'b1;
              if (susp_q) begin
                held_d = held_q + CW'(1);
              end else begin
                rel_d = rel_q + CW'(1);
              end
            end
          end
          if (!susp_q && item_i.last) begin
            skip_d = 1'b0;
          end
        end
        OP_SUSPEND: begin
          held_d = '0;
          susp_d = 1'b1;
          skip_d = 1'b0;
          if (wsum >= (CW + 1)'(QUEUE_DEPTH)) begin
            wp_d = PW'(wsum - (CW + 1)'(QUEUE_DEPTH));
          end else begin
            wp_d = PW'(wsum);
          end
        end
        OP_RESUME: begin
          if (susp_q) begin
            rel_d  = rel_q + held_q;
            held_d = '0;
            susp_d = 1'b0;
            skip_d = 1'b0;
          end
        end
        default: begin
          if (bits_q == '0) begin
            start = (rel_q != '0);
          end else if (tick_q < limit) begin
            tick_d = tick_q + TICK_W'(1);
          end else begin
            bits_d = bits_q - BITS_W'(1);
            if (bits_q != BITS_W'(1)) begin
              line_d  = shift_q[0];
              shift_d = shift_q >> 1;
              tick_d  = TICK_W'(1);
            end else begin
              line_d = 1'b1;
              tick_d = '0;
              start  = (rel_q != '0);
            end
          end
        end
      endcase
    end
    if (start) begin
      line_d  = 1'b0;
      shift_d = {1'b1, head};
      bits_d  = FRAME_BITS;
      tick_d  = TICK_W'(1);
      rp_d    = rp_inc;
      rel_d   = rel_q - CW'(1);
    end
  end

  // The byte at the read pointer is kept in head_q; a write into an empty queue
  // lands there directly, and a started frame fetches the following entry.
  always_comb begin
    pf_d   = start;
    head_d = head_q;
    if (mem_we && (wp_q == rp_q)) begin
      head_d = item_i.data;
    end else if (pf_q) begin
      head_d = rd_q;
    end
  end

  always_comb begin
    held_ext       = {{HELD_W{1'b0}}, held_d};
    res_o.pin      = line_d;
    res_o.accepted = ok;
    res_o.busy     = (bits_d != '0) || (rel_d != '0);
    res_o.held     = held_ext[HELD_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_ticks_q <= BIT_TICKS_RESET;
      wp_q        <= '0;
      rp_q        <= '0;
      rel_q       <= '0;
      held_q      <= '0;
      susp_q      <= 1'b0;
      skip_q      <= 1'b0;
      shift_q     <= '0;
      bits_q      <= '0;
      tick_q      <= '0;
      line_q      <= 1'b1;
      pf_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        bit_ticks_q <= cfg_wdata_i;
      end
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      rel_q   <= rel_d;
      held_q  <= held_d;
      susp_q  <= susp_d;
      skip_q  <= skip_d;
      shift_q <= shift_d;
      bits_q  <= bits_d;
      tick_q  <= tick_d;
      line_q  <= line_d;
      pf_q    <= pf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wp_q] <= item_i.data;
    end
    rd_q <= mem_q[rp_inc];
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import uth_pkg::*;

  localparam int unsigned QDEPTH = 4096;
  localparam int unsigned PTR_W = $clog2(QDEPTH);
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned N_ROWS = 25;
  localparam int unsigned N_PHASES = 6;
  localparam res_t ANY = '0;

  typedef enum int unsigned {RX_STREAM, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_e;

  typedef struct packed {
    op_e               op;
    logic [DATA_W-1:0] data;
    logic              last;
    logic              pinned;
    res_t              want;
  } row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [TICK_W-1:0] cfg_wdata_i = '0;
  logic              push = 1'b0;
  logic              full;
  logic [FUNC_W-1:0] func_i = '0;
  logic [DATA_W-1:0] data_i = '0;
  logic              last_of_write_i = 1'b0;
  logic              empty;
  logic              pop = 1'b0;
  logic              pin_o;
  logic              accepted_o;
  logic              busy_res_o;
  logic [HELD_W-1:0] held_count_o;

  logic pinned_vld = 1'b0;
  res_t pinned_res = '0;

  // Transmitter state as the predictor sees it.
  logic [DATA_W-1:0] store_mem [QDEPTH];
  logic [PTR_W-1:0]  wr_idx;
  logic [PTR_W-1:0]  rd_idx;
  logic [HELD_W-1:0] n_released;
  logic [HELD_W-1:0] n_held;
  logic              is_suspended;
  logic              skipping;
  logic [9:0]        shift_reg;
  logic [BITS_W-1:0] bits_left;
  logic [TICK_W-1:0] tick_cnt;
  logic              line_lvl;
  logic [TICK_W-1:0] period;

  res_t status_due [$];

  int unsigned mismatches = 0;
  int unsigned n_cycles = 0;
  int unsigned n_items = 0;
  int unsigned n_results = 0;
  int unsigned n_taken = 0;
  int unsigned n_refused = 0;
  int unsigned peak_held = 0;
  int unsigned burst_left = 0;
  int unsigned rx_left = 0;
  rx_mode_e    rx_mode = RX_STREAM;

  row_t script [N_ROWS] = '{
    '{OP_TICK,    8'hFF, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 13'd0}},
    '{OP_RESUME,  8'h00, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b0, 13'd0}},
    '{OP_WRITE,   8'hFF, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b1, 13'd0}},
    '{OP_TICK,    8'h00, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b1, 13'd0}},
    '{OP_WRITE,   8'h00, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b1, 13'd0}},
    '{OP_WRITE,   8'h55, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b1, 13'd0}},
    '{OP_WRITE,   8'h80, 1'b1, 1'b1, '{1'b0, 1'b1, 1'b1, 13'd0}},
    '{OP_SUSPEND, 8'hFF, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b1, 13'd0}},
    '{OP_WRITE,   8'h01, 1'b0, 1'b1, '{1'b0, 1'b1, 1'b1, 13'd1}},
    '{OP_WRITE,   8'h7F, 1'b1, 1'b1, '{1'b0, 1'b1, 1'b1, 13'd2}},
    '{OP_SUSPEND, 8'h00, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b1, 13'd0}},
    '{OP_WRITE,   8'hAA, 1'b1, 1'b1, '{1'b0, 1'b1, 1'b1, 13'd1}},
    '{OP_WRITE,   8'h00, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b1, 13'd1}},
    '{OP_WRITE,   8'h33, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b1, 13'd1}},
    '{OP_RESUME,  8'hFF, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b1, 13'd0}},
    '{OP_WRITE,   8'hFE, 1'b1, 1'b1, '{1'b0, 1'b1, 1'b1, 13'd0}},
    '{OP_TICK,    8'hFF, 1'b1, 1'b0, ANY},
    '{OP_TICK,    8'h00, 1'b0, 1'b0, ANY},
    '{OP_TICK,    8'hA5, 1'b1, 1'b0, ANY},
    '{OP_TICK,    8'h5A, 1'b0, 1'b0, ANY},
    '{OP_RESUME,  8'h0F, 1'b1, 1'b0, ANY},
    '{OP_TICK,    8'hF0, 1'b0, 1'b0, ANY},
    '{OP_SUSPEND, 8'h3C, 1'b0, 1'b0, ANY},
    '{OP_TICK,    8'hC3, 1'b1, 1'b0, ANY},
    '{OP_RESUME,  8'h81, 1'b0, 1'b0, ANY}
  };

  uart_tx_with_hold_buffer #(
    .QUEUE_DEPTH(QDEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push           (push),
    .full           (full),
    .func_i         (func_i),
    .data_i         (data_i),
    .last_of_write_i(last_of_write_i),
    .empty          (empty),
    .pop            (pop),
    .pin_o          (pin_o),
    .accepted_o     (accepted_o),
    .busy_res_o     (busy_res_o),
    .held_count_o   (held_count_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void clear_model();
    wr_idx = '0;
    rd_idx = '0;
    n_released = '0;
    n_held = '0;
    is_suspended = 1'b0;
    skipping = 1'b0;
    shift_reg = '0;
    bits_left = '0;
    tick_cnt = '0;
    line_lvl = 1'b1;
    period = BIT_TICKS_RESET;
  endfunction

  function automatic void launch_frame();
    logic [DATA_W-1:0] b;
    b = store_mem[rd_idx];
    rd_idx = rd_idx + 1'b1;
    n_released = n_released - 1'b1;
    line_lvl = 1'b0;
    shift_reg = {1'b0, 1'b1, b};
    bits_left = FRAME_BITS;
    tick_cnt = 16'd1;
  endfunction

  function automatic void apply_tick();
    logic [TICK_W-1:0] lim;
    lim = (period == '0) ? 16'd1 : period;
    if (bits_left == '0) begin
      if (n_released != '0) launch_frame();
    end else if (tick_cnt < lim) begin
      tick_cnt = tick_cnt + 1'b1;
    end else begin
      bits_left = bits_left - 1'b1;
      if (bits_left != '0) begin
        line_lvl = shift_reg[0];
        shift_reg = shift_reg >> 1;
        tick_cnt = 16'd1;
      end else begin
        line_lvl = 1'b1;
        tick_cnt = '0;
        if (n_released != '0) launch_frame();
      end
    end
  endfunction

  function automatic res_t tx_step(item_t it);
    res_t r;
    logic taken;
    taken = 1'b0;
    case (it.op)
      OP_WRITE: begin
        if (!skipping) begin
          if (it.data == '0) begin
            skipping = 1'b1;
          end else if (n_released + n_held < QDEPTH) begin
            store_mem[wr_idx] = it.data;
            wr_idx = wr_idx + 1'b1;
            if (is_suspended) n_held = n_held + 1'b1;
            else n_released = n_released + 1'b1;
            taken = 1'b1;
          end
        end
        if (!is_suspended && it.last) skipping = 1'b0;
      end
      OP_SUSPEND: begin
        n_held = '0;
        wr_idx = rd_idx + PTR_W'(n_released);
        is_suspended = 1'b1;
        skipping = 1'b0;
      end
      OP_RESUME: begin
        if (is_suspended) begin
          n_released = n_released + n_held;
          n_held = '0;
          is_suspended = 1'b0;
          skipping = 1'b0;
        end
      end
      default: apply_tick();
    endcase
    r.pin = line_lvl;
    r.accepted = taken;
    r.busy = (bits_left != '0) || (n_released != '0);
    r.held = n_held;
    return r;
  endfunction

  function automatic void check_field(string name, logic [HELD_W-1:0] want,
                                      logic [HELD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    item_t it;
    res_t  pred;
    res_t  want;
    if (!rst_ni) begin
      clear_model();
    end else begin
      if (cfg_we_i) period = cfg_wdata_i;
      if (push && !full) begin
        it.op = op_e'(func_i);
        it.data = data_i;
        it.last = last_of_write_i;
        pred = tx_step(it);
        n_items++;
        if (pred.accepted) n_taken++;
        else if (it.op == OP_WRITE) n_refused++;
        if (pred.held > peak_held) peak_held = pred.held;
        status_due.push_back(pinned_vld ? pinned_res : pred);
      end
      if (pop && !empty) begin
        if (status_due.size() == 0) begin
          $error("result transfer with no status expected");
          mismatches++;
        end else begin
          want = status_due.pop_front();
          n_results++;
          check_field("pin", want.pin, pin_o);
          check_field("accepted", want.accepted, accepted_o);
          check_field("busy_res", want.busy, busy_res_o);
          check_field("held_count", want.held, held_count_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(4, 48);
    end
    rx_left--;
    case (rx_mode)
      RX_STREAM: pop <= 1'b1;
      RX_COIN:   pop <= 1'($urandom);
      RX_SPARSE: pop <= ($urandom_range(0, 7) == 0);
      default:   pop <= 1'b0;
    endcase
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $error("no progress after %0d cycles", CYCLE_LIMIT);
      $display("testbench failed");
      $finish;
    end
  end

  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 32);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_item(op_e op, logic [DATA_W-1:0] d, logic l, logic pinned,
                           res_t want);
    push <= 1'b1;
    func_i <= op;
    data_i <= d;
    last_of_write_i <= l;
    pinned_vld <= pinned;
    pinned_res <= want;
    do @(posedge clk_i); while (full);
    pace();
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk_i); while (status_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_period(logic [TICK_W-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic fill_queue(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      send_item(OP_WRITE, 8'($urandom_range(1, 255)), 1'($urandom), 1'b0, ANY);
    end
  endtask

  task automatic run_phase(int unsigned n, int unsigned tick_pct);
    int unsigned sent;
    int unsigned r;
    int unsigned len;
    bit paused;
    logic [DATA_W-1:0] d;
    sent = 0;
    paused = 1'b0;
    while (sent < n) begin
      if (!paused && sent >= n / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < tick_pct) begin
        send_item(OP_TICK, 8'($urandom), 1'($urandom), 1'b0, ANY);
        sent++;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          len = $urandom_range(1, 6);
          for (int unsigned k = 0; k < len; k++) begin
            d = ($urandom_range(0, 15) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
            send_item(OP_WRITE, d, k == len - 1, 1'b0, ANY);
            sent++;
            if ($urandom_range(0, 3) == 0) begin
              send_item(OP_TICK, 8'($urandom), 1'($urandom), 1'b0, ANY);
              sent++;
            end
          end
        end else if (r < 82) begin
          send_item(OP_SUSPEND, 8'($urandom), 1'($urandom), 1'b0, ANY);
          sent++;
        end else if (r < 95) begin
          send_item(OP_RESUME, 8'($urandom), 1'($urandom), 1'b0, ANY);
          sent++;
        end else begin
          send_item(OP_WRITE, 8'($urandom), 1'($urandom), 1'b0, ANY);
          sent++;
        end
      end
    end
  endtask

  initial begin
    logic [TICK_W-1:0] periods [N_PHASES];
    int unsigned       counts [N_PHASES];
    periods = '{16'd1, 16'd0, 16'd3, 16'hFFFF, 16'd2, 16'd5};
    counts = '{220, 200, 200, 60, 200, 200};
    periods[N_PHASES-1] = 16'($urandom_range(1, 7));
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      send_item(script[i].op, script[i].data, script[i].last, script[i].pinned,
                script[i].want);
    end

    // Still at the reset bit period; tick-heavy so bits actually advance.
    run_phase(300, 80);
    for (int unsigned p = 0; p < N_PHASES; p++) begin
      wait_drained();
      set_period(periods[p]);
      run_phase(counts[p], 55);
    end

    wait_drained();
    set_period(16'd1);
    send_item(OP_SUSPEND, 8'h00, 1'b0, 1'b0, ANY);
    repeat (24) send_item(OP_TICK, 8'($urandom), 1'($urandom), 1'b0, ANY);

    // Fill the hold buffer, then discard it.
    fill_queue(6);
    send_item(OP_SUSPEND, 8'hFF, 1'b1, 1'b0, ANY);
    send_item(OP_RESUME, 8'h00, 1'b0, 1'b0, ANY);

    // Released bytes while the line is running.
    fill_queue(6);
    send_item(OP_SUSPEND, 8'h00, 1'b1, 1'b0, ANY);
    send_item(OP_WRITE, 8'h42, 1'b1, 1'b0, ANY);
    send_item(OP_TICK, 8'h00, 1'b0, 1'b0, ANY);
    send_item(OP_WRITE, 8'h24, 1'b0, 1'b0, ANY);
    send_item(OP_RESUME, 8'hFF, 1'b0, 1'b0, ANY);
    repeat (3) send_item(OP_TICK, 8'($urandom), 1'($urandom), 1'b0, ANY);

    wait_drained();
    $display("Covered %0d items and %0d result transfers: %0d bytes queued or held,",
             n_items, n_results, n_taken);
    $display("%0d writes refused, held count up to %0d, bit periods 0, 1, 2, 3, 200, 65535.",
             n_refused, peak_held);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/uth_pkg.sv
sv/uth_fifo.sv
sv/uth_front.sv
sv/uth_engine.sv
sv/uart_tx_with_hold_buffer.sv
verif/testbench.sv
